// ===== src/tcl_pkg.sv =====
// shared types, widths and coefficient tables for the two-channel lux calculation
// no dependencies; imported by every module of the block
package tcl_pkg;

  // channel widths
  localparam int CNT_W     = 16;
  localparam int SCALE_W   = 16;
  localparam int CH_SHIFT  = 10;
  localparam int CH_W      = CNT_W + SCALE_W - CH_SHIFT;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h7517;

  // ratio divider
  localparam int RATIO_SHIFT = 9;
  localparam int NUM_W       = CH_W + RATIO_SHIFT + 1;
  localparam int QUO_W       = 12;
  localparam int RATIO_W     = QUO_W;
  localparam int CMP_W       = CH_W + QUO_W;

  // coefficients and result
  localparam int COEF_W    = 10;
  localparam int PROD_W    = CH_W + COEF_W;
  localparam int LUX_SHIFT = 14;
  localparam int LUX_W     = 18;
  localparam int SEGMENTS  = 7;

  // stream and register port widths
  localparam int IN_TDATA_W  = 2 * CNT_W;
  localparam int OUT_TDATA_W = 24;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam logic REG_CHANNEL_SCALE = 1'b0;

  // breakpoints and coefficient pairs, one per segment
  localparam logic [COEF_W-1:0] BRK_K [SEGMENTS] = '{
    10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a
  };
  localparam logic [COEF_W-1:0] COEF_B [SEGMENTS] = '{
    10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037
  };
  localparam logic [COEF_W-1:0] COEF_M [SEGMENTS] = '{
    10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b
  };

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
  } chan_pair_t;

  typedef struct packed {
    chan_pair_t           ch;
    logic [NUM_W-1:0]     rem;
    logic [QUO_W-1:0]     quo;
    logic                 zero;
    logic                 sat;
  } div_stage_t;

  typedef struct packed {
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] m;
  } coef_t;

  // first segment whose breakpoint is not below the ratio; zero past the last one
  function automatic coef_t seg_coef(input logic [RATIO_W-1:0] ratio);
    coef_t c;
    c = '0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (ratio <= RATIO_W'(BRK_K[i])) begin
        c.b = COEF_B[i];
        c.m = COEF_M[i];
      end
    end
    return c;
  endfunction

endpackage

// ===== src/tcl_divider.sv =====
// pipelined restoring divider: (c1 << 10) / c0, one quotient bit per stage
// depends on tcl_pkg; quotients that do not fit QUO_W bits are flagged as saturated
module tcl_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  tcl_pkg::chan_pair_t in_ch,
  output logic               out_valid,
  output tcl_pkg::div_stage_t out_st
);
  import tcl_pkg::*;

  div_stage_t       st [QUO_W+1];
  logic [QUO_W:0]   vld;
  div_stage_t       init_st;
  logic [NUM_W-1:0] num;

  // setup: numerator, zero-divisor mark, overflow check against c0 << QUO_W
  always_comb begin
    num             = {in_ch.c1, {(NUM_W - CH_W){1'b0}}};
    init_st.ch      = in_ch;
    init_st.rem     = num;
    init_st.quo     = '0;
    init_st.zero    = (in_ch.c0 == '0);
    init_st.sat     = (in_ch.c0 != '0) &&
                      (CMP_W'(num) >= CMP_W'({in_ch.c0, {QUO_W{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      st[0] <= init_st;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int K = QUO_W - 1 - i;
    logic [CMP_W-1:0] dsh;
    logic             fits;
    div_stage_t       nxt;

    always_comb begin
      dsh  = CMP_W'(st[i].ch.c0) << K;
      fits = !st[i].zero && (CMP_W'(st[i].rem) >= dsh);
      nxt  = st[i];
      if (fits) begin
        nxt.rem    = st[i].rem - NUM_W'(dsh);
        nxt.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_st    = st[QUO_W];

endmodule

// ===== src/tcl_lux_tail.sv =====
// segment lookup, the two coefficient products and the clamped, rounded lux value
// depends on tcl_pkg; the lux value leaves combinationally from the product stage
module tcl_lux_tail (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  tcl_pkg::div_stage_t          in_st,
  output logic                         out_valid,
  output logic [tcl_pkg::LUX_W-1:0]    lux
);
  import tcl_pkg::*;

  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (LUX_SHIFT - 1);

  logic [QUO_W:0]   quo_inc;
  logic [RATIO_W-1:0] ratio;
  coef_t            coef_nxt;
  coef_t            coef;
  chan_pair_t       ch;
  logic             v_coef;
  logic [PROD_W-1:0] pos;
  logic [PROD_W-1:0] neg;
  logic             v_prod;
  logic [PROD_W-1:0] diff;
  logic [PROD_W:0]  acc;

  // rounded ratio and coefficient pick
  always_comb begin
    quo_inc  = {1'b0, in_st.quo} + (QUO_W + 1)'(1);
    ratio    = in_st.zero ? '0 : quo_inc[QUO_W:1];
    coef_nxt = in_st.sat ? '0 : seg_coef(ratio);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_coef <= 1'b0;
      v_prod <= 1'b0;
    end else if (en) begin
      v_coef <= in_valid;
      v_prod <= v_coef;
    end
    if (en) begin
      coef <= coef_nxt;
      ch   <= in_st.ch;
      pos  <= PROD_W'(ch.c0) * PROD_W'(coef.b);
      neg  <= PROD_W'(ch.c1) * PROD_W'(coef.m);
    end
  end

  // clamp at zero, round half up, drop the fraction
  always_comb begin
    diff = (pos > neg) ? (pos - neg) : '0;
    acc  = {1'b0, diff} + ROUND_HALF;
  end

  assign out_valid = v_prod;
  assign lux       = acc[LUX_SHIFT+LUX_W-1:LUX_SHIFT];

endmodule

// ===== src/tcl_skid.sv =====
// two-entry output buffer: output register plus skid register
// depends on tcl_pkg; in_ready is registered so it never depends combinationally on m_ready
module tcl_skid (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tcl_pkg::LUX_W-1:0] in_data,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [tcl_pkg::LUX_W-1:0] m_data
);
  import tcl_pkg::*;

  logic             sk_valid;
  logic [LUX_W-1:0] sk_data;
  logic             push;

  assign in_ready = !sk_valid;
  assign push     = in_valid && !sk_valid;

  // output register drains the skid first, otherwise takes the new beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_valid || m_ready) begin
      if (sk_valid) begin
        m_valid  <= 1'b1;
        sk_valid <= 1'b0;
      end else begin
        m_valid  <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
    if (!m_valid || m_ready) begin
      m_data <= sk_valid ? sk_data : in_data;
    end else if (push) begin
      sk_data <= in_data;
    end
  end

endmodule

// ===== src/two_channel_lux_calc_unit.sv =====
// Two-channel lux calculation: takes one broadband/infrared count pair per cycle and
// returns one rounded lux value per pair, in order. Most of the pipeline depth is in the
// ratio divider, which resolves one quotient bit per stage over twelve stages. Throughput
// is one beat per cycle; s_tready falls only once the two-entry output buffer is full.
// channel_scale lives at byte address 0 of the register port and should be changed
// only while no beats are in flight.
// depends on tcl_pkg, tcl_divider, tcl_lux_tail, tcl_skid
module two_channel_lux_calc_unit (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream: [15:0] broadband_count, [31:16] infrared_count
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tcl_pkg::IN_TDATA_W-1:0]    s_tdata,
  // master stream: [17:0] lux_value, [23:18] zero
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tcl_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcl_pkg::ADDR_W-1:0]        paddr,
  input  logic [tcl_pkg::DATA_W-1:0]        pwdata,
  output logic [tcl_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import tcl_pkg::*;

  logic [SCALE_W-1:0] channel_scale;
  logic               en;
  logic               v_in;
  logic [CNT_W-1:0]   broadband_count;
  logic [CNT_W-1:0]   infrared_count;
  logic               v_sc;
  chan_pair_t         ch_sc;
  logic               dv_valid;
  div_stage_t         dv_st;
  logic               tail_valid;
  logic [LUX_W-1:0]   lux_value;
  logic [LUX_W-1:0]   m_lux;
  logic               reg_hit;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1] == REG_CHANNEL_SCALE);
  assign prdata  = reg_hit ? DATA_W'(channel_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      channel_scale <= pwdata[SCALE_W-1:0];
    end
  end

  // the whole pipeline advances while the output buffer has room
  assign s_tready = en;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= s_tvalid;
    end
    if (en) begin
      broadband_count <= s_tdata[CNT_W-1:0];
      infrared_count  <= s_tdata[2*CNT_W-1:CNT_W];
    end
  end

  // integration-time scaling of both channels
  always_ff @(posedge clk) begin
    if (rst) begin
      v_sc <= 1'b0;
    end else if (en) begin
      v_sc <= v_in;
    end
    if (en) begin
      ch_sc.c0 <= CH_W'((CNT_W + SCALE_W)'(broadband_count * channel_scale) >> CH_SHIFT);
      ch_sc.c1 <= CH_W'((CNT_W + SCALE_W)'(infrared_count * channel_scale) >> CH_SHIFT);
    end
  end

  tcl_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_sc),
    .in_ch     (ch_sc),
    .out_valid (dv_valid),
    .out_st    (dv_st)
  );

  tcl_lux_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .in_st     (dv_st),
    .out_valid (tail_valid),
    .lux       (lux_value)
  );

  tcl_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tail_valid),
    .in_ready (en),
    .in_data  (lux_value),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_data   (m_lux)
  );

  assign m_tdata = OUT_TDATA_W'(m_lux);

  // a full skid register means a result is waiting on the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result on the output");

  // the buffer only fills while the output is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  // a zero broadband channel never reads as a saturated ratio
  a_zero_not_sat: assert property (@(posedge clk) disable iff (rst)
    dv_valid && dv_st.zero |-> !dv_st.sat)
    else $error("zero divisor flagged as saturated");

endmodule
